// ----- hw/rtl/mrs_pkg.sv -----
// shared types and constants for the modbus rtu slave frame engine
package mrs_pkg;

  localparam int REG_COUNT_DEF     = 128;
  localparam int MAX_READ_REGS_DEF = 29;

  localparam logic [7:0]  OPEN_ID  = 8'd247;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FUNC_RD_HOLD = 8'd3;
  localparam logic [7:0] FUNC_RD_INP  = 8'd4;
  localparam logic [7:0] FUNC_WR      = 8'd6;

  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_RD_HOLD = 2'd1;
  localparam logic [1:0] CMD_RD_INP  = 2'd2;
  localparam logic [1:0] CMD_WR      = 2'd3;

  localparam logic RES_TX   = 1'b0;
  localparam logic RES_READ = 1'b1;

  localparam logic [1:0] CFG_DEVICE_ID = 2'd0;

  typedef enum logic [2:0] {
    K_RX      = 3'd0,
    K_END     = 3'd1,
    K_WR_HOLD = 3'd2,
    K_WR_INP  = 3'd3,
    K_RD_HOLD = 3'd4,
    K_RD_INP  = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LREAD,
    S_CHK_FEED,
    S_CHK_WAIT,
    S_CHK_CMP,
    S_R_NEXT,
    S_R_MEM,
    S_R_WAIT,
    S_CRC_LO,
    S_CRC_HI
  } state_t;

  typedef struct packed {
    logic       init;
    logic       start;
    logic [7:0] din;
  } crc_ctl_t;

  typedef struct packed {
    logic wr_en;
    logic wr_inp;
    logic rd_en;
    logic rd_inp;
  } mem_ctl_t;

endpackage

// ----- hw/rtl/mrs_crc.sv -----
// bit-serial crc-16 unit, one bit per cycle
module mrs_crc (
  input  logic            clk,
  input  logic            rst_n,
  input  mrs_pkg::crc_ctl_t ctl,
  output logic [15:0]     crc,
  output logic            busy
);

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        fb;

  assign busy = (cnt_r != 4'd0);
  assign crc  = crc_r;
  assign fb   = crc_r[0] ^ sh_r[0];

  always_comb begin
    crc_nxt = crc_r;
    sh_nxt  = sh_r;
    cnt_nxt = cnt_r;
    if (ctl.init) begin
      crc_nxt = mrs_pkg::CRC_INIT;
    end else if (ctl.start) begin
      sh_nxt  = ctl.din;
      cnt_nxt = 4'd8;
    end else if (busy) begin
      crc_nxt = {1'b0, crc_r[15:1]} ^ (fb ? mrs_pkg::CRC_POLY : 16'd0);
      sh_nxt  = {1'b0, sh_r[7:1]};
      cnt_nxt = cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= mrs_pkg::CRC_INIT;
      cnt_r <= 4'd0;
    end else begin
      crc_r <= crc_nxt;
      cnt_r <= cnt_nxt;
    end
    sh_r <= sh_nxt;
  end

endmodule

// ----- hw/rtl/mrs_regfile.sv -----
// holding and input register memories with clearing pass after reset
module mrs_regfile #(
  parameter int REG_COUNT = mrs_pkg::REG_COUNT_DEF,
  parameter int AW        = $clog2(REG_COUNT)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mrs_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]     wr_addr,
  input  logic [15:0]       wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [15:0]       rd_data,
  output logic              clearing
);

  logic [15:0]   hold_mem [REG_COUNT];
  logic [15:0]   inp_mem  [REG_COUNT];
  logic [15:0]   hold_q_r, inp_q_r;
  logic          rd_inp_r;
  logic          clearing_r;
  logic [AW-1:0] clr_cnt_r;

  assign clearing = clearing_r;
  assign rd_data  = rd_inp_r ? inp_q_r : hold_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(REG_COUNT - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      hold_mem[clr_cnt_r] <= 16'd0;
    end else if (ctl.wr_en && !ctl.wr_inp) begin
      hold_mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      hold_q_r <= hold_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      inp_mem[clr_cnt_r] <= 16'd0;
    end else if (ctl.wr_en && ctl.wr_inp) begin
      inp_mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      inp_q_r  <= inp_mem[rd_addr];
      rd_inp_r <= ctl.rd_inp;
    end
  end

endmodule

// ----- hw/rtl/mrs_ctrl.sv -----
// frame collection, check and reply sequencer with output register
module mrs_ctrl #(
  parameter int REG_COUNT     = mrs_pkg::REG_COUNT_DEF,
  parameter int MAX_READ_REGS = mrs_pkg::MAX_READ_REGS_DEF,
  parameter int AW            = $clog2(REG_COUNT)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          dev_id,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_kind,
  input  logic [7:0]          in_rx_byte,
  input  logic [6:0]          in_reg_index,
  input  logic [15:0]         in_reg_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_result_kind,
  output logic [7:0]          out_tx_byte,
  output logic                out_last,
  output logic [15:0]         out_read_value,
  output logic [1:0]          out_cmd_code,
  output logic [15:0]         out_cmd_addr,
  output logic [15:0]         out_cmd_value,
  output mrs_pkg::crc_ctl_t   crc_ctl,
  input  logic [15:0]         crc,
  input  logic                crc_busy,
  output mrs_pkg::mem_ctl_t   mem_ctl,
  output logic [AW-1:0]       wr_addr,
  output logic [15:0]         wr_data,
  output logic [AW-1:0]       rd_addr,
  input  logic [15:0]         rd_data,
  input  logic                clearing
);

  mrs_pkg::state_t state_r, state_nxt;

  logic [7:0]    fs_r [8];
  logic [3:0]    cnt_r;
  logic [1:0]    code_r;
  logic [7:0]    id_r;
  logic [5:0]    pos_r;
  logic [5:0]    total_r;
  logic [AW-1:0] ptr_r;
  logic [15:0]   word_r;
  logic          lr_ok_r;

  logic          out_valid_r;
  logic          res_kind_r;
  logic [7:0]    tx_r;
  logic          last_r;
  logic [15:0]   rv_r;
  logic [1:0]    code_out_r;
  logic [15:0]   addr_out_r;
  logic [15:0]   val_out_r;

  logic          acc;
  logic          out_take;
  logic          tx_load;
  logic [7:0]    tx_byte;
  logic          tx_last;
  logic          lr_load;
  logic [7:0]    fs_rd;
  logic [15:0]   f_addr, f_val;
  logic          addr_ok;
  logic [1:0]    f_code;
  logic          frame_go;
  logic          crc_ok;
  logic          rd_bad;
  logic          idx_ok;
  logic          is_data;
  logic          seq_done;

  assign acc      = in_valid && in_ready;
  assign out_take = out_valid_r && out_ready;
  assign fs_rd    = fs_r[pos_r[2:0]];
  assign f_addr   = {fs_r[2], fs_r[3]};
  assign f_val    = {fs_r[4], fs_r[5]};
  assign addr_ok  = (fs_r[0] == dev_id) || (fs_r[0] == mrs_pkg::OPEN_ID);
  assign crc_ok   = (crc == {fs_r[7], fs_r[6]});
  assign idx_ok   = 32'(in_reg_index) < 32'(REG_COUNT);
  assign rd_bad   = (f_val == 16'd0) || (32'(f_val) > 32'(MAX_READ_REGS))
                    || ((17'(f_addr) + 17'(f_val)) > 17'(REG_COUNT));
  assign is_data  = (code_r != mrs_pkg::CMD_WR) && (pos_r >= 6'd3);
  assign seq_done = (pos_r + 6'd1) == total_r;

  always_comb begin
    case (fs_r[1])
      mrs_pkg::FUNC_RD_HOLD: f_code = mrs_pkg::CMD_RD_HOLD;
      mrs_pkg::FUNC_RD_INP:  f_code = mrs_pkg::CMD_RD_INP;
      mrs_pkg::FUNC_WR:      f_code = mrs_pkg::CMD_WR;
      default:               f_code = mrs_pkg::CMD_NONE;
    endcase
  end

  assign frame_go = (cnt_r == 4'd8) && addr_ok && (f_code != mrs_pkg::CMD_NONE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mrs_pkg::S_CLEAR: begin
        if (!clearing) state_nxt = mrs_pkg::S_IDLE;
      end
      mrs_pkg::S_IDLE: begin
        if (acc) begin
          case (in_kind)
            mrs_pkg::K_END:     if (frame_go) state_nxt = mrs_pkg::S_CHK_FEED;
            mrs_pkg::K_RD_HOLD: state_nxt = mrs_pkg::S_LREAD;
            mrs_pkg::K_RD_INP:  state_nxt = mrs_pkg::S_LREAD;
            default:            state_nxt = mrs_pkg::S_IDLE;
          endcase
        end
      end
      mrs_pkg::S_LREAD:    state_nxt = mrs_pkg::S_IDLE;
      mrs_pkg::S_CHK_FEED: state_nxt = mrs_pkg::S_CHK_WAIT;
      mrs_pkg::S_CHK_WAIT: begin
        if (!crc_busy) begin
          state_nxt = (pos_r == 6'd5) ? mrs_pkg::S_CHK_CMP : mrs_pkg::S_CHK_FEED;
        end
      end
      mrs_pkg::S_CHK_CMP: begin
        if (!crc_ok || (code_r != mrs_pkg::CMD_WR && rd_bad)) begin
          state_nxt = mrs_pkg::S_IDLE;
        end else begin
          state_nxt = mrs_pkg::S_R_NEXT;
        end
      end
      mrs_pkg::S_R_NEXT: begin
        state_nxt = (is_data && pos_r[0]) ? mrs_pkg::S_R_MEM : mrs_pkg::S_R_WAIT;
      end
      mrs_pkg::S_R_MEM: state_nxt = mrs_pkg::S_R_WAIT;
      mrs_pkg::S_R_WAIT: begin
        if (!crc_busy && !out_valid_r) begin
          state_nxt = seq_done ? mrs_pkg::S_CRC_LO : mrs_pkg::S_R_NEXT;
        end
      end
      mrs_pkg::S_CRC_LO: state_nxt = mrs_pkg::S_CRC_HI;
      mrs_pkg::S_CRC_HI: begin
        if (!out_valid_r) state_nxt = mrs_pkg::S_IDLE;
      end
      default: state_nxt = mrs_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready    = 1'b0;
    crc_ctl     = '0;
    mem_ctl     = '0;
    wr_addr     = AW'(in_reg_index);
    wr_data     = in_reg_value;
    rd_addr     = AW'(in_reg_index);
    tx_load     = 1'b0;
    tx_byte     = 8'd0;
    tx_last     = 1'b0;
    lr_load     = 1'b0;
    case (state_r)
      mrs_pkg::S_IDLE: begin
        in_ready = !out_valid_r;
        if (acc) begin
          case (in_kind)
            mrs_pkg::K_END: crc_ctl.init = 1'b1;
            mrs_pkg::K_WR_HOLD: mem_ctl.wr_en = idx_ok;
            mrs_pkg::K_WR_INP: begin
              mem_ctl.wr_en  = idx_ok;
              mem_ctl.wr_inp = 1'b1;
            end
            mrs_pkg::K_RD_HOLD: mem_ctl.rd_en = 1'b1;
            mrs_pkg::K_RD_INP: begin
              mem_ctl.rd_en  = 1'b1;
              mem_ctl.rd_inp = 1'b1;
            end
            default: ;
          endcase
        end
      end
      mrs_pkg::S_LREAD: lr_load = 1'b1;
      mrs_pkg::S_CHK_FEED: begin
        crc_ctl.start = 1'b1;
        crc_ctl.din   = fs_rd;
      end
      mrs_pkg::S_CHK_CMP: begin
        crc_ctl.init  = 1'b1;
        wr_addr       = AW'(f_addr);
        wr_data       = f_val;
        mem_ctl.wr_en = crc_ok && (code_r == mrs_pkg::CMD_WR)
                        && (32'(f_addr) < 32'(REG_COUNT));
      end
      mrs_pkg::S_R_NEXT: begin
        rd_addr = ptr_r;
        if (is_data && pos_r[0]) begin
          mem_ctl.rd_en  = 1'b1;
          mem_ctl.rd_inp = (code_r == mrs_pkg::CMD_RD_INP);
        end else begin
          tx_load = 1'b1;
          if (is_data) begin
            tx_byte = word_r[7:0];
          end else if (pos_r == 6'd0) begin
            tx_byte = id_r;
          end else if (pos_r == 6'd1) begin
            tx_byte = fs_r[1];
          end else if (code_r == mrs_pkg::CMD_WR) begin
            tx_byte = fs_rd;
          end else begin
            tx_byte = {fs_r[5][6:0], 1'b0};
          end
          crc_ctl.start = 1'b1;
          crc_ctl.din   = tx_byte;
        end
      end
      mrs_pkg::S_R_MEM: begin
        tx_load       = 1'b1;
        tx_byte       = rd_data[15:8];
        crc_ctl.start = 1'b1;
        crc_ctl.din   = rd_data[15:8];
      end
      mrs_pkg::S_CRC_LO: begin
        tx_load = 1'b1;
        tx_byte = crc[7:0];
      end
      mrs_pkg::S_CRC_HI: begin
        if (!out_valid_r) begin
          tx_load      = 1'b1;
          tx_byte      = crc[15:8];
          tx_last      = 1'b1;
          crc_ctl.init = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mrs_pkg::S_CLEAR;
      cnt_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (acc && in_kind == mrs_pkg::K_RX && cnt_r < 4'd8) begin
        cnt_r <= cnt_r + 4'd1;
      end else if (acc && in_kind == mrs_pkg::K_END) begin
        cnt_r <= 4'd0;
      end
      if (tx_load || lr_load) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // frame store and payload
  always_ff @(posedge clk) begin
    if (acc && in_kind == mrs_pkg::K_RX && cnt_r < 4'd8) begin
      fs_r[cnt_r[2:0]] <= in_rx_byte;
    end
    if (acc) begin
      lr_ok_r <= idx_ok;
      code_r  <= f_code;
      id_r    <= (fs_r[0] == mrs_pkg::OPEN_ID) ? mrs_pkg::OPEN_ID : dev_id;
      pos_r   <= 6'd0;
    end
    if (state_r == mrs_pkg::S_CHK_WAIT && !crc_busy && pos_r != 6'd5) begin
      pos_r <= pos_r + 6'd1;
    end
    if (state_r == mrs_pkg::S_CHK_CMP) begin
      pos_r   <= 6'd0;
      ptr_r   <= AW'(f_addr);
      total_r <= (code_r == mrs_pkg::CMD_WR) ? 6'd6 : 6'd3 + {f_val[4:0], 1'b0};
    end
    if (state_r == mrs_pkg::S_R_NEXT && is_data && pos_r[0]) begin
      ptr_r <= ptr_r + AW'(1);
    end
    if (state_r == mrs_pkg::S_R_MEM) begin
      word_r <= rd_data;
    end
    if (state_r == mrs_pkg::S_R_WAIT && !crc_busy && !out_valid_r && !seq_done) begin
      pos_r <= pos_r + 6'd1;
    end
    if (tx_load) begin
      res_kind_r <= mrs_pkg::RES_TX;
      tx_r       <= tx_byte;
      last_r     <= tx_last;
      rv_r       <= 16'd0;
      code_out_r <= code_r;
      addr_out_r <= f_addr;
      val_out_r  <= f_val;
    end else if (lr_load) begin
      res_kind_r <= mrs_pkg::RES_READ;
      tx_r       <= 8'd0;
      last_r     <= 1'b0;
      rv_r       <= lr_ok_r ? rd_data : 16'd0;
      code_out_r <= mrs_pkg::CMD_NONE;
      addr_out_r <= 16'd0;
      val_out_r  <= 16'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = res_kind_r;
  assign out_tx_byte     = tx_r;
  assign out_last        = last_r;
  assign out_read_value  = rv_r;
  assign out_cmd_code    = code_out_r;
  assign out_cmd_addr    = addr_out_r;
  assign out_cmd_value   = val_out_r;

`ifndef ASSERT_OFF
  a_crc_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    crc_ctl.start |-> !crc_busy)
    else $error("crc started while busy");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (tx_load || lr_load) |-> !out_valid_r)
    else $error("output register overwritten");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 4'd8)
    else $error("frame count beyond eight");

  a_no_request_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == mrs_pkg::S_IDLE && !clearing))
    else $error("request taken outside idle");
`endif

endmodule

// ----- hw/rtl/modbus_rtu_slave_frame_engine.sv -----
// top level of the modbus rtu slave frame engine with apb register port
//
// requests on in_* carry received bytes, frame end marks and local register
// writes and reads; results on out_* carry reply bytes (result_kind 0, last
// on the final crc byte) or local read data (result_kind 1).
// a received byte or local write is stored when it is accepted; a local read
// passes through the memory read register and then the output register.
// a frame end runs a bit-serial crc over six bytes and compares it with the
// last two bytes; then each reply byte goes through the same crc unit, the high
// byte of a register after its memory read, and the two crc bytes are sent last.
// a new request is taken only when the sequencer is idle and the output
// register is empty; a stalled receiver holds the reply in place.
// after reset both register memories are cleared, one entry per cycle, before
// the first request is taken; configuration writes are taken throughout.
// device_id resets to 1.
module modbus_rtu_slave_frame_engine #(
  parameter int REG_COUNT     = mrs_pkg::REG_COUNT_DEF,
  parameter int MAX_READ_REGS = mrs_pkg::MAX_READ_REGS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_rx_byte,
  input  logic [6:0]  in_reg_index,
  input  logic [15:0] in_reg_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_last,
  output logic [15:0] out_read_value,
  output logic [1:0]  out_cmd_code,
  output logic [15:0] out_cmd_addr,
  output logic [15:0] out_cmd_value
);

  localparam int AW = $clog2(REG_COUNT);

  logic [7:0]        dev_id_r;
  mrs_pkg::crc_ctl_t crc_ctl;
  logic [15:0]       crc;
  logic              crc_busy;
  mrs_pkg::mem_ctl_t mem_ctl;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [15:0]       wr_data, rd_data;
  logic              clearing;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == mrs_pkg::CFG_DEVICE_ID) ? {24'd0, dev_id_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_id_r <= 8'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr == mrs_pkg::CFG_DEVICE_ID) begin
      dev_id_r <= cfg_pwdata[7:0];
    end
  end

  mrs_crc u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (crc_ctl),
    .crc   (crc),
    .busy  (crc_busy)
  );

  mrs_regfile #(
    .REG_COUNT (REG_COUNT),
    .AW        (AW)
  ) u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mem_ctl),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  mrs_ctrl #(
    .REG_COUNT     (REG_COUNT),
    .MAX_READ_REGS (MAX_READ_REGS),
    .AW            (AW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .dev_id          (dev_id_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_rx_byte      (in_rx_byte),
    .in_reg_index    (in_reg_index),
    .in_reg_value    (in_reg_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_tx_byte     (out_tx_byte),
    .out_last        (out_last),
    .out_read_value  (out_read_value),
    .out_cmd_code    (out_cmd_code),
    .out_cmd_addr    (out_cmd_addr),
    .out_cmd_value   (out_cmd_value),
    .crc_ctl         (crc_ctl),
    .crc             (crc),
    .crc_busy        (crc_busy),
    .mem_ctl         (mem_ctl),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .clearing        (clearing)
  );

endmodule
